/* rtl/core/codebook_coherence_check_macros.svh */
// Assertion macros shared by the codebook coherence checker RTL.
// Included by modules that carry concurrent checks; needs clock and reset in scope.
`ifndef CODEBOOK_COHERENCE_CHECK_MACROS_SVH
`define CODEBOOK_COHERENCE_CHECK_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CCC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("codebook coherence check failed");

// Antecedent implies consequent on the next edge.
`define CCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("codebook coherence sequence check failed");

`endif

/* rtl/core/ccc_pkg.sv */
// Package for the codebook coherence checker: payload structs, codes, constants.
// No dependencies; imported by the top level and by ccc_isqrt (ccc_div does not use it).
`default_nettype none

package ccc_pkg;

   // fixed point widths
   localparam int MU_W   = 18;          // pair coherence before saturation
   localparam int ISQ_W  = 36;          // square root radicand
   localparam int ROOT_W = ISQ_W / 2;
   localparam int SAT_W  = 15;

   localparam logic [31:0] UNIT_SQ_LOW  = 32'd267094957;
   localparam logic [31:0] UNIT_SQ_HIGH = 32'd269779311;

   // register indexes
   localparam logic [1:0] CSR_CHANNELS = 2'd0;
   localparam logic [1:0] CSR_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_WARN     = 2'd2;
   localparam logic [1:0] CSR_FAIL     = 2'd3;

   localparam logic [14:0] WARN_RESET = 15'd8192;
   localparam logic [14:0] FAIL_RESET = 15'd12288;

   // grades and causes
   localparam logic [1:0] QUAL_GOOD   = 2'd0;
   localparam logic [1:0] QUAL_WARN   = 2'd1;
   localparam logic [1:0] QUAL_FAILED = 2'd2;

   localparam logic [1:0] CAUSE_NONE  = 2'd0;
   localparam logic [1:0] CAUSE_DIMS  = 2'd1;
   localparam logic [1:0] CAUSE_UNIT  = 2'd2;
   localparam logic [1:0] CAUSE_COHER = 2'd3;

   typedef struct packed {
      logic signed [15:0] elem_re;
      logic signed [15:0] elem_im;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  quality;
      logic [1:0]  fail_cause;
      logic        dims_ok;
      logic        unit_ok;
      logic        coherence_ok;
      logic [14:0] mu_max;
      logic [3:0]  worst_first;
      logic [3:0]  worst_second;
      logic [6:0]  pair_count;
      logic [14:0] mu_avg;
      logic [14:0] mu_rms;
   } rsp_type;

   function automatic logic [SAT_W-1:0] sat15(input logic [63:0] v);
      logic [SAT_W-1:0] r;
      if (v > 64'd32767) r = 15'd32767;
      else r = v[SAT_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/codebook_coherence_check.sv */
// Codebook coherence checker, top level. Uses ccc_pkg, ccc_div, ccc_isqrt, macros header.
// Load: one element per cycle, stall stays low while idle; results leave via an output register.
// After the last element: settle and dimension states, then per channel pair a read and multiply
//   phases per element on the shared multiplier, two divides, square states SQ0-SQ2, a root
//   and accumulate states ACC0/ACC1; then two divides and a root for mean/RMS. Stall is high throughout.
// Synchronous active-high reset clears control and counters and loads the register defaults; store needs no clear.
`default_nettype none
`include "codebook_coherence_check_macros.svh"

module codebook_coherence_check
   import ccc_pkg::*;
#(
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_LENGTH   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // element input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int DEPTH   = MAX_CHANNELS * MAX_LENGTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LC_W    = $clog2(DEPTH + 2);
   localparam int ACC_W   = 34 + $clog2(MAX_LENGTH);
   localparam int PAIR_W  = $clog2(MAX_CHANNELS * (MAX_CHANNELS - 1) / 2 + 1);
   localparam int SUM_W   = MU_W + PAIR_W;
   localparam int SQ_W    = 2 * MU_W + PAIR_W;
   localparam int DIV_W   = (ACC_W > SQ_W) ? ACC_W : SQ_W;
   localparam int DEN_W   = (PAIR_W > 7) ? PAIR_W : 7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SETTLE, ST_DIMS, ST_PAIR, ST_READ, ST_MUL, ST_DIV_RE, ST_DIV_IM,
      ST_SQ0, ST_SQ1, ST_SQ2, ST_ROOT, ST_ACC0, ST_ACC1, ST_AVG, ST_RMS_DIV,
      ST_RMS_ROOT, ST_GRADE, ST_REPORT
   } state_type;

   // ---------------------------------------------------------------- registers
   logic [4:0]  nch_ff;
   logic [6:0]  len_ff;
   logic [14:0] warn_ff;
   logic [14:0] fail_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff  <= '0;
         len_ff  <= '0;
         warn_ff <= WARN_RESET;
         fail_ff <= FAIL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHANNELS: nch_ff  <= csr_data[4:0];
            CSR_LENGTH:   len_ff  <= csr_data[6:0];
            CSR_WARN:     warn_ff <= csr_data[14:0];
            CSR_FAIL:     fail_ff <= csr_data[14:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- load path
   state_type state_ff;
   logic      req_fire;
   logic      report_fire;
   logic      rsp_valid_ff;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign report_fire = (state_ff == ST_REPORT) && (!rsp_valid_ff || !rsp_stall);

   logic [LC_W-1:0] lc_ff;
   logic            all_unit_ff;
   // unit magnitude test is split: squares registered, then sum and range compare
   logic            chk_v_ff;
   logic [30:0]     sqr_ff;
   logic [30:0]     sqi_ff;
   logic [31:0]     sq_sum;
   logic signed [31:0] re_sq;
   logic signed [31:0] im_sq;

   assign re_sq  = req_data.elem_re * req_data.elem_re;
   assign im_sq  = req_data.elem_im * req_data.elem_im;
   assign sq_sum = {1'b0, sqr_ff} + {1'b0, sqi_ff};

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req_fire && (lc_ff < LC_W'(DEPTH)))
         mem[lc_ff[ADDR_W-1:0]] <= {req_data.elem_im, req_data.elem_re};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff       <= '0;
         all_unit_ff <= 1'b1;
         chk_v_ff    <= 1'b0;
      end else begin
         chk_v_ff <= req_fire;
         if (req_fire) begin
            sqr_ff <= re_sq[30:0];
            sqi_ff <= im_sq[30:0];
            if (lc_ff < LC_W'(DEPTH)) lc_ff <= lc_ff + 1'b1;
            else lc_ff <= LC_W'(DEPTH + 1);
         end
         if (chk_v_ff && ((sq_sum < UNIT_SQ_LOW) || (sq_sum > UNIT_SQ_HIGH)))
            all_unit_ff <= 1'b0;
         // book is done: start the next one clean
         if (report_fire) begin
            lc_ff       <= '0;
            all_unit_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- shared units
   logic [31:0]              rd_a_ff;
   logic [31:0]              rd_b_ff;
   logic [ADDR_W:0]          ptr_a_ff;
   logic [ADDR_W:0]          ptr_b_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_a_ff <= mem[ptr_a_ff[ADDR_W-1:0]];
         rd_b_ff <= mem[ptr_b_ff[ADDR_W-1:0]];
      end
   end

   logic [2:0]               phase_ff;
   logic signed [32:0]       mul_a;
   logic signed [32:0]       mul_b;
   logic signed [65:0]       prod_ff;
   logic [31:0]              ur_ff;
   logic [31:0]              ui_ff;
   logic [MU_W-1:0]          mu_ff;

   // single multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            case (phase_ff)
               3'd0: begin
                  mul_a = 33'(signed'(rd_a_ff[15:0]));
                  mul_b = 33'(signed'(rd_b_ff[15:0]));
               end
               3'd1: begin
                  mul_a = 33'(signed'(rd_a_ff[31:16]));
                  mul_b = 33'(signed'(rd_b_ff[31:16]));
               end
               3'd2: begin
                  mul_a = 33'(signed'(rd_a_ff[15:0]));
                  mul_b = 33'(signed'(rd_b_ff[31:16]));
               end
               3'd3: begin
                  mul_a = 33'(signed'(rd_a_ff[31:16]));
                  mul_b = 33'(signed'(rd_b_ff[15:0]));
               end
               default: ;
            endcase
         end
         ST_SQ0: begin
            mul_a = {1'b0, ur_ff};
            mul_b = {1'b0, ur_ff};
         end
         ST_SQ1: begin
            mul_a = {1'b0, ui_ff};
            mul_b = {1'b0, ui_ff};
         end
         ST_ACC0: begin
            mul_a = 33'(mu_ff);
            mul_b = 33'(mu_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   logic signed [ACC_W-1:0] re_acc_ff;
   logic signed [ACC_W-1:0] im_acc_ff;
   logic [ACC_W-1:0]        re_abs;
   logic [ACC_W-1:0]        im_abs;
   logic [SUM_W-1:0]        sum_ff;
   logic [SQ_W-1:0]         sumsq_ff;
   logic [PAIR_W-1:0]       pairs_ff;
   logic                    launch_ff;

   assign re_abs = re_acc_ff[ACC_W-1] ? ACC_W'(-re_acc_ff) : ACC_W'(re_acc_ff);
   assign im_abs = im_acc_ff[ACC_W-1] ? ACC_W'(-im_acc_ff) : ACC_W'(im_acc_ff);

   logic [DIV_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic             div_start;

   always_comb begin
      div_num = DIV_W'(sumsq_ff);
      div_den = DEN_W'(pairs_ff);
      case (state_ff)
         ST_DIV_RE: begin
            div_num = DIV_W'(re_abs);
            div_den = DEN_W'(len_ff);
         end
         ST_DIV_IM: begin
            div_num = DIV_W'(im_abs);
            div_den = DEN_W'(len_ff);
         end
         ST_AVG: div_num = DIV_W'(sum_ff);
         default: ;
      endcase
   end

   assign div_start = launch_ff && ((state_ff == ST_DIV_RE) || (state_ff == ST_DIV_IM) ||
                                    (state_ff == ST_AVG) || (state_ff == ST_RMS_DIV));

   ccc_div #(.N_W(DIV_W), .D_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   logic [63:0]        sqs_ff;
   logic [ISQ_W-1:0]   sq_rad;
   logic               sq_start;
   logic               sq_done;
   logic [ROOT_W-1:0]  sq_root;

   assign sq_rad   = (state_ff == ST_ROOT) ? sqs_ff[63:28] : div_quot[ISQ_W-1:0];
   assign sq_start = launch_ff && ((state_ff == ST_ROOT) || (state_ff == ST_RMS_ROOT));

   ccc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sq_rad),
      .done  (sq_done),
      .root  (sq_root)
   );

   // ---------------------------------------------------------------- sequencer
   logic [5:0]        a_ff;
   logic [5:0]        b_ff;
   logic [6:0]        k_ff;
   logic [ADDR_W:0]   base_a_ff;
   logic [ADDR_W:0]   base_b_ff;
   logic [MU_W-1:0]   mmax_ff;
   logic [5:0]        wi_ff;
   logic [5:0]        wj_ff;
   logic [DIV_W-1:0]  avg_ff;
   logic [MU_W-1:0]   rms_ff;
   rsp_type           res_ff;
   rsp_type           rsp_ff;
   logic              dims_bad;

   assign dims_bad = (nch_ff == 5'd0) || (len_ff == 7'd0) ||
                     (32'(nch_ff) > 32'(MAX_CHANNELS)) || (32'(len_ff) > 32'(MAX_LENGTH)) ||
                     (32'(lc_ff) != 32'(nch_ff) * 32'(len_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         launch_ff    <= 1'b0;
         phase_ff     <= '0;
      end else begin
         launch_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_data.is_last) state_ff <= ST_SETTLE;
            end
            // last element's magnitude test lands this cycle
            ST_SETTLE: state_ff <= ST_DIMS;
            ST_DIMS: begin
               res_ff    <= '0;
               sum_ff    <= '0;
               sumsq_ff  <= '0;
               mmax_ff   <= '0;
               wi_ff     <= '0;
               wj_ff     <= '0;
               pairs_ff  <= '0;
               avg_ff    <= '0;
               rms_ff    <= '0;
               a_ff      <= 6'd0;
               b_ff      <= 6'd1;
               base_a_ff <= '0;
               base_b_ff <= (ADDR_W+1)'(len_ff);
               if (dims_bad) begin
                  res_ff.quality    <= QUAL_FAILED;
                  res_ff.fail_cause <= CAUSE_DIMS;
                  state_ff          <= ST_REPORT;
               end else if (!all_unit_ff) begin
                  res_ff.quality    <= QUAL_FAILED;
                  res_ff.fail_cause <= CAUSE_UNIT;
                  res_ff.dims_ok    <= 1'b1;
                  state_ff          <= ST_REPORT;
               end else if (nch_ff < 5'd2) begin
                  state_ff <= ST_GRADE;
               end else begin
                  state_ff <= ST_PAIR;
               end
            end
            ST_PAIR: begin
               re_acc_ff <= '0;
               im_acc_ff <= '0;
               k_ff      <= '0;
               ptr_a_ff  <= base_a_ff;
               ptr_b_ff  <= base_b_ff;
               state_ff  <= ST_READ;
            end
            ST_READ: begin
               phase_ff <= '0;
               state_ff <= ST_MUL;
            end
            // conj(a)*b: re += ar*br + ai*bi, im += ar*bi - ai*br
            ST_MUL: begin
               phase_ff <= phase_ff + 1'b1;
               case (phase_ff)
                  3'd1, 3'd2: re_acc_ff <= re_acc_ff + ACC_W'(prod_ff);
                  3'd3: im_acc_ff <= im_acc_ff + ACC_W'(prod_ff);
                  3'd4: im_acc_ff <= im_acc_ff - ACC_W'(prod_ff);
                  default: ;
               endcase
               if (phase_ff == 3'd4) begin
                  k_ff     <= k_ff + 1'b1;
                  ptr_a_ff <= ptr_a_ff + 1'b1;
                  ptr_b_ff <= ptr_b_ff + 1'b1;
                  if (k_ff + 1'b1 == len_ff) begin
                     state_ff  <= ST_DIV_RE;
                     launch_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_DIV_RE: begin
               if (!launch_ff && div_done) begin
                  ur_ff     <= div_quot[31:0];
                  state_ff  <= ST_DIV_IM;
                  launch_ff <= 1'b1;
               end
            end
            ST_DIV_IM: begin
               if (!launch_ff && div_done) begin
                  ui_ff    <= div_quot[31:0];
                  state_ff <= ST_SQ0;
               end
            end
            ST_SQ0: state_ff <= ST_SQ1;
            ST_SQ1: begin
               sqs_ff   <= prod_ff[63:0];
               state_ff <= ST_SQ2;
            end
            ST_SQ2: begin
               sqs_ff    <= sqs_ff + prod_ff[63:0];
               state_ff  <= ST_ROOT;
               launch_ff <= 1'b1;
            end
            ST_ROOT: begin
               if (!launch_ff && sq_done) begin
                  mu_ff    <= sq_root;
                  state_ff <= ST_ACC0;
               end
            end
            ST_ACC0: begin
               sum_ff   <= sum_ff + SUM_W'(mu_ff);
               pairs_ff <= pairs_ff + 1'b1;
               // first pair to reach the maximum keeps it
               if (mu_ff > mmax_ff) begin
                  mmax_ff <= mu_ff;
                  wi_ff   <= a_ff;
                  wj_ff   <= b_ff;
               end
               state_ff <= ST_ACC1;
            end
            ST_ACC1: begin
               sumsq_ff <= sumsq_ff + SQ_W'(prod_ff[2*MU_W-1:0]);
               if (b_ff + 6'd1 < 6'(nch_ff)) begin
                  b_ff      <= b_ff + 6'd1;
                  base_b_ff <= base_b_ff + (ADDR_W+1)'(len_ff);
                  state_ff  <= ST_PAIR;
               end else if (a_ff + 6'd2 < 6'(nch_ff)) begin
                  a_ff      <= a_ff + 6'd1;
                  b_ff      <= a_ff + 6'd2;
                  base_a_ff <= base_a_ff + (ADDR_W+1)'(len_ff);
                  base_b_ff <= base_a_ff + (ADDR_W+1)'({len_ff, 1'b0});
                  state_ff  <= ST_PAIR;
               end else begin
                  state_ff  <= ST_AVG;
                  launch_ff <= 1'b1;
               end
            end
            ST_AVG: begin
               if (!launch_ff && div_done) begin
                  avg_ff    <= div_quot;
                  state_ff  <= ST_RMS_DIV;
                  launch_ff <= 1'b1;
               end
            end
            ST_RMS_DIV: begin
               if (!launch_ff && div_done) begin
                  state_ff  <= ST_RMS_ROOT;
                  launch_ff <= 1'b1;
               end
            end
            ST_RMS_ROOT: begin
               if (!launch_ff && sq_done) begin
                  rms_ff   <= sq_root;
                  state_ff <= ST_GRADE;
               end
            end
            ST_GRADE: begin
               res_ff.dims_ok <= 1'b1;
               res_ff.unit_ok <= 1'b1;
               if (mmax_ff >= MU_W'(fail_ff)) begin
                  res_ff.quality      <= QUAL_FAILED;
                  res_ff.fail_cause   <= CAUSE_COHER;
                  res_ff.coherence_ok <= 1'b0;
               end else if (mmax_ff >= MU_W'(warn_ff)) begin
                  res_ff.quality      <= QUAL_WARN;
                  res_ff.fail_cause   <= CAUSE_NONE;
                  res_ff.coherence_ok <= 1'b1;
               end else begin
                  res_ff.quality      <= QUAL_GOOD;
                  res_ff.fail_cause   <= CAUSE_NONE;
                  res_ff.coherence_ok <= 1'b1;
               end
               res_ff.mu_max       <= sat15(64'(mmax_ff));
               res_ff.worst_first  <= 4'(wi_ff);
               res_ff.worst_second <= 4'(wj_ff);
               res_ff.pair_count   <= 7'(pairs_ff);
               res_ff.mu_avg       <= sat15(64'(avg_ff));
               res_ff.mu_rms       <= sat15(64'(rms_ff));
               state_ff            <= ST_REPORT;
            end
            // wait for the output register to free up
            ST_REPORT: begin
               if (report_fire) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   `CCC_ASSERT(a_lc_bound, lc_ff <= LC_W'(DEPTH + 1))
   `CCC_ASSERT_NEXT(a_last_starts_eval, req_fire && req_data.is_last, state_ff == ST_SETTLE)
   `CCC_ASSERT_NEXT(a_report_clears, report_fire, lc_ff == '0 && all_unit_ff && rsp_valid_ff)
   `CCC_ASSERT(a_read_in_range, state_ff != ST_READ || 32'(ptr_b_ff) < 32'(DEPTH))

endmodule

`default_nettype wire

/* rtl/core/ccc_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing but its parameters.
`default_nettype none

module ccc_div #(
   parameter int N_W = 48,
   parameter int D_W = 12
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] num,
   input  wire logic [D_W-1:0] den,
   output logic                done,
   output logic [N_W-1:0]      quot
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [D_W-1:0]   rem_ff;
   logic [D_W-1:0]   den_ff;
   logic [N_W-1:0]   quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [D_W:0]     trial;
   logic             take;

   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(N_W);
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            if (take) rem_ff <= D_W'(trial - {1'b0, den_ff});
            else rem_ff <= trial[D_W-1:0];
            quo_ff <= {quo_ff[N_W-2:0], take};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/ccc_isqrt.sv */
// Integer square root, two radicand bits per cycle, floor result.
// Depends on ccc_pkg for the radicand width.
`default_nettype none

module ccc_isqrt
   import ccc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ISQ_W-1:0]  rad,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [ISQ_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              take;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[ISQ_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
            rad_ff  <= rad;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= take ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], take};
            rad_ff  <= {rad_ff[ISQ_W-3:0], 2'b00};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire
